// ===== rtl/rbad_pkg.sv =====
// Shared types, widths and register codes for the RGB block-average downscaler.
package rbad_pkg;

  localparam int unsigned Colors       = 3;
  localparam int unsigned ColorW       = 8;
  localparam int unsigned SumW         = 16;
  localparam int unsigned SumWordW     = Colors * SumW;
  localparam int unsigned BlkSizeW     = 5;
  localparam int unsigned FrameW       = 11;
  localparam int unsigned PosW         = 10;
  localparam int unsigned InBlkW       = 4;
  localparam int unsigned AreaW        = 9;
  localparam int unsigned PrdW         = 16;
  localparam int unsigned MaxFrameEdge = 1024;

  localparam int unsigned DefMaxBlockColumns = 64;
  localparam int unsigned DefMaxBlockSize    = 16;

  // register indexes (byte address / 4)
  localparam logic [1:0] RegBlockSize   = 2'd0;
  localparam logic [1:0] RegFrameWidth  = 2'd1;
  localparam logic [1:0] RegFrameHeight = 2'd2;

  localparam logic [BlkSizeW-1:0] RstBlockSize   = 5'd10;
  localparam logic [FrameW-1:0]   RstFrameWidth  = 11'd320;
  localparam logic [FrameW-1:0]   RstFrameHeight = 11'd240;

  // what the position tracker says about the pixel being accepted
  typedef struct packed {
    logic            in_range;
    logic            first_row;
    logic            emit;
    logic            frame_done;
    logic [PosW-1:0] block_x;
    logic [PosW-1:0] block_y;
  } pix_info_t;

endpackage

// ===== rtl/rbad_sum_mem.sv =====
// Column partial-sum memory: one write port, one registered read port.
module rbad_sum_mem import rbad_pkg::*; #(
  parameter int unsigned Depth = DefMaxBlockColumns,
  parameter int unsigned AddrW = 6
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  output logic [SumWordW-1:0] rd_data_o,
  input  logic                wr_en_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  logic [SumWordW-1:0] wr_data_i
);

  logic [SumWordW-1:0] mem [Depth];
  logic [SumWordW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/rbad_pos.sv =====
// Raster position tracker: pixel, in-block and block counters plus block tests.
module rbad_pos import rbad_pkg::*; #(
  parameter int unsigned MaxBlockColumns = DefMaxBlockColumns
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [BlkSizeW-1:0] blk_size_i,
  input  logic [FrameW-1:0]   frame_w_i,
  input  logic [FrameW-1:0]   frame_h_i,
  input  logic                accept_i,
  input  logic                frame_start_i,
  output pix_info_t           info_o
);

  localparam logic [PosW:0] ColLimit = (PosW+1)'(MaxBlockColumns);
  localparam logic [PosW:0] LastCol  = (PosW+1)'(MaxBlockColumns - 1);

  logic [PosW-1:0]   px_q, py_q, bx_q, by_q;
  logic [InBlkW-1:0] xib_q, yib_q;
  logic [PosW-1:0]   px_d, py_d, bx_d, by_d;
  logic [InBlkW-1:0] xib_d, yib_d;

  logic [PosW-1:0]   px_e, py_e, bx_e, by_e;
  logic [InBlkW-1:0] xib_e, yib_e;
  logic [PosW:0]     bx_n1, by_n1, px_n1, py_n1;
  logic [BlkSizeW-1:0] xib_n1, yib_n1;
  logic [PrdW-1:0]   x_end, y_end;
  logic              in_x, in_y, last_x, last_y, blk_x_end, blk_y_end;

  always_comb begin
    px_e  = frame_start_i ? '0 : px_q;
    py_e  = frame_start_i ? '0 : py_q;
    bx_e  = frame_start_i ? '0 : bx_q;
    by_e  = frame_start_i ? '0 : by_q;
    xib_e = frame_start_i ? '0 : xib_q;
    yib_e = frame_start_i ? '0 : yib_q;

    bx_n1  = {1'b0, bx_e} + 1'b1;
    by_n1  = {1'b0, by_e} + 1'b1;
    px_n1  = {1'b0, px_e} + 1'b1;
    py_n1  = {1'b0, py_e} + 1'b1;
    xib_n1 = {1'b0, xib_e} + 1'b1;
    yib_n1 = {1'b0, yib_e} + 1'b1;

    // block k covers pixels up to (k+1)*size; whole when that fits
    x_end = PrdW'(bx_n1) * PrdW'(blk_size_i);
    y_end = PrdW'(by_n1) * PrdW'(blk_size_i);

    in_x   = ({1'b0, bx_e} < ColLimit) && (x_end <= PrdW'(frame_w_i));
    in_y   = y_end <= PrdW'(frame_h_i);
    last_x = ({1'b0, bx_e} == LastCol) || ((x_end + PrdW'(blk_size_i)) > PrdW'(frame_w_i));
    last_y = (y_end + PrdW'(blk_size_i)) > PrdW'(frame_h_i);

    blk_x_end = xib_n1 >= blk_size_i;
    blk_y_end = yib_n1 >= blk_size_i;

    info_o.in_range   = in_x && in_y;
    info_o.first_row  = (yib_e == '0);
    info_o.emit       = blk_x_end && blk_y_end;
    info_o.frame_done = last_x && last_y;
    info_o.block_x    = bx_e;
    info_o.block_y    = by_e;

    // advance
    px_d  = px_n1[PosW-1:0];
    py_d  = py_e;
    bx_d  = bx_e;
    by_d  = by_e;
    xib_d = xib_n1[InBlkW-1:0];
    yib_d = yib_e;
    if (PrdW'(px_n1) >= PrdW'(frame_w_i)) begin
      px_d  = '0;
      xib_d = '0;
      bx_d  = '0;
      if (PrdW'(py_n1) >= PrdW'(frame_h_i)) begin
        py_d  = '0;
        yib_d = '0;
        by_d  = '0;
      end else begin
        py_d = py_n1[PosW-1:0];
        if (blk_y_end) begin
          yib_d = '0;
          by_d  = by_n1[PosW-1:0];
        end else begin
          yib_d = yib_n1[InBlkW-1:0];
        end
      end
    end else if (blk_x_end) begin
      xib_d = '0;
      bx_d  = bx_n1[PosW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q  <= '0;
      py_q  <= '0;
      bx_q  <= '0;
      by_q  <= '0;
      xib_q <= '0;
      yib_q <= '0;
    end else if (accept_i) begin
      px_q  <= px_d;
      py_q  <= py_d;
      bx_q  <= bx_d;
      by_q  <= by_d;
      xib_q <= xib_d;
      yib_q <= yib_d;
    end
  end

endmodule

// ===== rtl/rbad_div.sv =====
// Three-lane restoring divider, one quotient bit per cycle, mean saturated to 8 bits.
module rbad_div import rbad_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [Colors-1:0][SumW-1:0]   num_i,
  input  logic [AreaW-1:0]              den_i,
  input  logic                          ack_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [Colors-1:0][ColorW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(SumW);
  localparam logic [1:0] DivIdle = 2'd0;
  localparam logic [1:0] DivRun  = 2'd1;
  localparam logic [1:0] DivDone = 2'd2;

  logic [1:0]                      state_q, state_d;
  logic [CntW-1:0]                 cnt_q;
  logic [AreaW-1:0]                den_q;
  logic [Colors-1:0][SumW-1:0]     num_q;
  logic [Colors-1:0][AreaW-1:0]    rem_q;
  logic [Colors-1:0][AreaW:0]      trial, diff;
  logic [Colors-1:0]               ge;

  always_comb begin
    for (int c = 0; c < Colors; c++) begin
      trial[c]  = {rem_q[c], num_q[c][SumW-1]};
      diff[c]   = trial[c] - {1'b0, den_q};
      ge[c]     = trial[c] >= {1'b0, den_q};
      quot_o[c] = (num_q[c][SumW-1:ColorW] != '0) ? '1 : num_q[c][ColorW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DivIdle: if (start_i) state_d = DivRun;
      DivRun:  if (cnt_q == '0) state_d = DivDone;
      DivDone: if (ack_i) state_d = DivIdle;
      default: state_d = DivIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DivIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == DivIdle && start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
      cnt_q <= CntW'(SumW - 1);
    end else if (state_q == DivRun) begin
      cnt_q <= cnt_q - 1'b1;
      for (int c = 0; c < Colors; c++) begin
        rem_q[c] <= ge[c] ? diff[c][AreaW-1:0] : trial[c][AreaW-1:0];
        num_q[c] <= {num_q[c][SumW-2:0], ge[c]};
      end
    end
  end

  assign busy_o = (state_q != DivIdle);
  assign done_o = (state_q == DivDone);

endmodule

// ===== rtl/rgb_block_average_downscaler_unit.sv =====
// Top level of the RGB block-average downscaler: config port, sum pipeline, output register.
//
//  channel   dir  handshake                  payload
//  s_axis    in   tvalid/tready              tdata {blue,green,red}, tuser frame_start
//  m_axis    out  tvalid/tready              tdata {block_row,block_col,b,g,r avg}, tlast
//  apb       in   psel/penable/pwrite/pready paddr 4b, pwdata/prdata 32b
//
// Pixels that finish no block move at one request per cycle: a read of the
// column-sum memory, then an add and write back the next cycle (a write to
// the entry being read is forwarded). A block-finishing pixel holds the input
// while the shared three-lane divider works out the means, and longer while the
// output register still holds an untaken result; the result then sits in the
// output register while input resumes.
// Reset clears counters and control; the sum memory needs no clearing pass.
module rgb_block_average_downscaler_unit import rbad_pkg::*; #(
  parameter int unsigned MaxBlockColumns = DefMaxBlockColumns,
  parameter int unsigned MaxBlockSize    = DefMaxBlockSize
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // pixel input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
  input  logic        s_axis_tuser,  // frame_start
  // block result
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // red_avg, green_avg, blue_avg, block_col[33:24],
                                     // block_row[43:34], zero fill
  output logic        m_axis_tlast,  // frame_done
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AddrW = (MaxBlockColumns > 1) ? $clog2(MaxBlockColumns) : 1;

  // ---------------- configuration registers ----------------
  logic [BlkSizeW-1:0] blk_size_q;
  logic [FrameW-1:0]   frame_w_q, frame_h_q;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_size_q <= RstBlockSize;
      frame_w_q  <= RstFrameWidth;
      frame_h_q  <= RstFrameHeight;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegBlockSize:   blk_size_q <= pwdata[BlkSizeW-1:0];
        RegFrameWidth:  frame_w_q  <= pwdata[FrameW-1:0];
        RegFrameHeight: frame_h_q  <= pwdata[FrameW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegBlockSize:   prdata = 32'(blk_size_q);
      RegFrameWidth:  prdata = 32'(frame_w_q);
      RegFrameHeight: prdata = 32'(frame_h_q);
      default:        prdata = '0;
    endcase
  end

  // out-of-range settings act as the nearest legal value
  logic [BlkSizeW-1:0] blk_size;
  logic [FrameW-1:0]   frame_w, frame_h;
  logic [AreaW-1:0]    area;

  always_comb begin
    if (blk_size_q == '0) blk_size = BlkSizeW'(1);
    else if (blk_size_q > BlkSizeW'(MaxBlockSize)) blk_size = BlkSizeW'(MaxBlockSize);
    else blk_size = blk_size_q;

    if (frame_w_q == '0) frame_w = FrameW'(1);
    else if (frame_w_q > FrameW'(MaxFrameEdge)) frame_w = FrameW'(MaxFrameEdge);
    else frame_w = frame_w_q;

    if (frame_h_q == '0) frame_h = FrameW'(1);
    else if (frame_h_q > FrameW'(MaxFrameEdge)) frame_h = FrameW'(MaxFrameEdge);
    else frame_h = frame_h_q;

    area = AreaW'(blk_size) * AreaW'(blk_size);
  end

  // ---------------- stage A: position and memory read ----------------
  pix_info_t info;
  logic      s_accept, div_busy, div_done, div_start, out_load;

  assign s_accept = s_axis_tvalid && s_axis_tready;

  rbad_pos #(
    .MaxBlockColumns(MaxBlockColumns)
  ) u_pos (
    .clk_i,
    .rst_ni,
    .blk_size_i   (blk_size),
    .frame_w_i    (frame_w),
    .frame_h_i    (frame_h),
    .accept_i     (s_accept),
    .frame_start_i(s_axis_tuser),
    .info_o       (info)
  );

  logic                          p_valid_q;
  logic                          p_first_q, p_emit_q, p_done_q;
  logic [AddrW-1:0]              p_addr_q;
  logic [PosW-1:0]               p_bx_q, p_by_q;
  logic [Colors-1:0][ColorW-1:0] p_color_q;
  logic                          fwd_hit_q;
  logic [SumWordW-1:0]           fwd_data_q;

  logic [AddrW-1:0]    rd_addr;
  logic [SumWordW-1:0] rd_data, wr_data;

  assign rd_addr = info.block_x[AddrW-1:0];

  // input waits while a block mean is in flight
  assign s_axis_tready = !div_busy && !(p_valid_q && p_emit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= s_accept && info.in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      p_first_q  <= info.first_row;
      p_emit_q   <= info.emit;
      p_done_q   <= info.frame_done;
      p_addr_q   <= rd_addr;
      p_bx_q     <= info.block_x;
      p_by_q     <= info.block_y;
      p_color_q  <= s_axis_tdata;
      // stage B writes this same entry at this edge: keep the new value
      fwd_hit_q  <= p_valid_q && (p_addr_q == rd_addr);
      fwd_data_q <= wr_data;
    end
  end

  rbad_sum_mem #(
    .Depth(MaxBlockColumns),
    .AddrW(AddrW)
  ) u_mem (
    .clk_i,
    .rd_en_i  (s_accept),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (p_valid_q),
    .wr_addr_i(p_addr_q),
    .wr_data_i(wr_data)
  );

  // ---------------- stage B: accumulate and write back ----------------
  logic [SumWordW-1:0]         old_sums;
  logic [Colors-1:0][SumW:0]   acc;
  logic [Colors-1:0][SumW-1:0] new_sums;

  assign old_sums = fwd_hit_q ? fwd_data_q : rd_data;

  always_comb begin
    for (int c = 0; c < Colors; c++) begin
      acc[c] = (SumW+1)'(p_color_q[c]);
      if (!p_first_q) acc[c] = acc[c] + (SumW+1)'(old_sums[c*SumW +: SumW]);
      new_sums[c] = acc[c][SumW] ? '1 : acc[c][SumW-1:0];
    end
  end

  assign wr_data   = new_sums;
  assign div_start = p_valid_q && p_emit_q;

  // ---------------- mean divider and output register ----------------
  logic [Colors-1:0][ColorW-1:0] quot;
  logic [PosW-1:0]               meta_bx_q, meta_by_q;
  logic                          meta_done_q;

  rbad_div u_div (
    .clk_i,
    .rst_ni,
    .start_i(div_start),
    .num_i  (new_sums),
    .den_i  (area),
    .ack_i  (out_load),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (quot)
  );

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      meta_bx_q   <= p_bx_q;
      meta_by_q   <= p_by_q;
      meta_done_q <= p_done_q;
    end
  end

  assign out_load = div_done && (!m_axis_tvalid || m_axis_tready);

  logic        m_valid_q;
  logic [47:0] m_data_q;
  logic        m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {4'b0, meta_by_q, meta_bx_q, quot};
      m_last_q <= meta_done_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule

// ===== rtl/rbad_checker.sv =====
// Port-level checks for the downscaler, bound to the top level.
module rbad_checker import rbad_pkg::*; #(
  parameter int unsigned MaxBlockColumns = DefMaxBlockColumns
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] prdata,
  input logic        pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // block column always addresses an existing sum entry
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (34'(m_axis_tdata[33:24]) < 34'(MaxBlockColumns)))
    else $error("block column out of range");

  // register reads are zero-extended above their field width
  a_rd_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && !pwrite && (paddr[3:2] == RegBlockSize) |-> prdata[31:BlkSizeW] == '0)
    else $error("block size read has stray upper bits");

  a_rd_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && !pwrite && ((paddr[3:2] == RegFrameWidth) || (paddr[3:2] == RegFrameHeight))
      |-> prdata[31:FrameW] == '0)
    else $error("frame size read has stray upper bits");

  // every access phase sees pready high, so no access is stalled
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable |-> pready)
    else $error("config access stalled");

endmodule

bind rgb_block_average_downscaler_unit rbad_checker #(
  .MaxBlockColumns(MaxBlockColumns)
) u_rbad_checker (.*);
